/* hdl/spq_pkg.sv */
// shared types, codes and defaults for the stable priority queue
// no dependencies
package spq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int STACK_DEPTH_DEF = 16;

  localparam int ID_W   = 16;
  localparam int PRIO_W = 2;

  localparam logic [PRIO_W-1:0] PRIO_MAX = 2'd2;
  localparam logic [PRIO_W-1:0] PRIO_LOW = 2'd0;

  typedef enum logic [1:0] {
    MODE_ENQ = 2'd0,
    MODE_DEQ = 2'd1,
    MODE_POP = 2'd2,
    MODE_NOP = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_DONE = 2'd2
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the request beat
    logic exec;   // apply it to queue and stack, register the result
  } cmd_t;

endpackage

/* hdl/stable_priority_queue_with_low_stack.sv */
// top level of the stable priority queue with low-priority stack
// depends on spq_pkg, spq_ctrl, spq_dp
//
// Each input beat is one request: enqueue (mode 0) a task id with priority
// 0 to 2, dequeue (mode 1) the queue head, or pop (mode 2) the low stack.
// The queue keeps larger priorities in front and equal priorities in
// arrival order; a priority of 3 is treated as 2. A priority 0 task is also
// pushed onto a last-in, first-out stack. Every request gives exactly one
// result beat with a status (0 ok, 1 empty on removal, 2 full on insert).
// Timing: a request is taken, executed in the following cycle and shown
// as a result in the cycle after; while the result is being taken the
// next request may be accepted, so a new request overlaps the result
// of the one before, but none is taken during execution. The
// execute cycle shifts all queue cells in parallel and reads or writes
// the stack memory at its top, whose registered read port sets the pace.
// No clearing pass is needed after reset.
module stable_priority_queue_with_low_stack import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic [ID_W-1:0]   in_task_id,
  input  logic [PRIO_W-1:0] in_priority_req,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [ID_W-1:0]   out_task_id,
  output logic [PRIO_W-1:0] out_priority,
  output logic              out_stack_pushed
);

  cmd_t cmd;

  // sequencer: accept, execute, present
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // queue cells, stack memory and result register
  spq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_mode          (in_mode),
    .in_task_id       (in_task_id),
    .in_priority_req  (in_priority_req),
    .out_status       (out_status),
    .out_task_id      (out_task_id),
    .out_priority     (out_priority),
    .out_stack_pushed (out_stack_pushed)
  );

endmodule

/* hdl/spq_ctrl.sv */
// sequencing fsm for the stable priority queue
// depends on spq_pkg
module spq_ctrl import spq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  always_comb begin
    unique case (state_r)
      S_IDLE:  in_stall = 1'b0;
      S_DONE:  in_stall = out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: state_nxt = S_DONE;
      S_DONE: begin
        if (accept) state_nxt = S_EXEC;
        else if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.load  = accept;
    cmd.exec  = (state_r == S_EXEC);
    out_valid = (state_r == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec) else $error("load not followed by exec");
  a_exec_then_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid) else $error("exec not followed by result");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !cmd.load) else $error("beat taken while executing");

endmodule

/* hdl/spq_dp.sv */
// datapath: sorted queue as a row of shifting cells, low stack in a memory
// depends on spq_pkg
module spq_dp import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic [1:0]        in_mode,
  input  logic [ID_W-1:0]   in_task_id,
  input  logic [PRIO_W-1:0] in_priority_req,
  output logic [1:0]        out_status,
  output logic [ID_W-1:0]   out_task_id,
  output logic [PRIO_W-1:0] out_priority,
  output logic              out_stack_pushed
);

  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SCNT_W = $clog2(STACK_DEPTH + 1);
  localparam int SIDX_W = $clog2(STACK_DEPTH);

  // captured request
  mode_t             mode_r;
  logic [ID_W-1:0]   id_r;
  logic [PRIO_W-1:0] prio_r;

  // queue cells
  logic [ID_W-1:0]   q_id_r   [QUEUE_DEPTH];
  logic [PRIO_W-1:0] q_prio_r [QUEUE_DEPTH];
  logic [QCNT_W-1:0] q_cnt_r, q_cnt_nxt;

  // stack
  logic [ID_W-1:0]   s_mem [STACK_DEPTH];
  logic [ID_W-1:0]   s_rd_r;
  logic [SCNT_W-1:0] s_cnt_r, s_cnt_nxt;
  logic [SCNT_W-1:0] s_top;
  logic              s_we;

  logic [QUEUE_DEPTH-1:0] ge;
  logic q_ok, q_ins, q_deq, s_try, s_ok, s_pop;

  status_t           st_nxt;
  logic [ID_W-1:0]   rid_nxt;
  logic [PRIO_W-1:0] rprio_nxt;
  logic              pushed_nxt;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode_t'(in_mode);
      id_r   <= in_task_id;
      prio_r <= (in_priority_req > PRIO_MAX) ? PRIO_MAX : in_priority_req;
    end
  end

  // occupied cells whose priority keeps them ahead of the new task
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ge[i] = (QCNT_W'(i) < q_cnt_r) && (q_prio_r[i] >= prio_r);
    end
  end

  always_comb begin
    q_ok       = (q_cnt_r < QCNT_W'(QUEUE_DEPTH));
    s_try      = (prio_r == PRIO_LOW);
    s_ok       = s_try && (s_cnt_r < SCNT_W'(STACK_DEPTH));
    q_ins      = 1'b0;
    q_deq      = 1'b0;
    s_we       = 1'b0;
    s_pop      = 1'b0;
    st_nxt     = ST_OK;
    rid_nxt    = '0;
    rprio_nxt  = '0;
    pushed_nxt = 1'b0;
    unique case (mode_r)
      MODE_ENQ: begin
        q_ins      = q_ok;
        s_we       = s_ok;
        pushed_nxt = s_ok;
        if (!q_ok || (s_try && !s_ok)) st_nxt = ST_FULL;
      end
      MODE_DEQ: begin
        if (q_cnt_r == '0) begin
          st_nxt = ST_EMPTY;
        end else begin
          q_deq     = 1'b1;
          rid_nxt   = q_id_r[0];
          rprio_nxt = q_prio_r[0];
        end
      end
      MODE_POP: begin
        if (s_cnt_r == '0) begin
          st_nxt = ST_EMPTY;
        end else begin
          s_pop   = 1'b1;
          rid_nxt = s_rd_r;
        end
      end
      default: st_nxt = ST_OK;
    endcase
  end

  always_comb begin
    q_cnt_nxt = q_cnt_r;
    if (q_ins)      q_cnt_nxt = q_cnt_r + 1'b1;
    else if (q_deq) q_cnt_nxt = q_cnt_r - 1'b1;
    s_cnt_nxt = s_cnt_r;
    if (s_we)       s_cnt_nxt = s_cnt_r + 1'b1;
    else if (s_pop) s_cnt_nxt = s_cnt_r - 1'b1;
  end

  // each cell keeps, takes the new task, or takes its neighbor's entry
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (q_ins && !ge[i]) begin
          if (i == 0 || ge[(i == 0) ? 0 : i - 1]) begin
            q_id_r[i]   <= id_r;
            q_prio_r[i] <= prio_r;
          end else begin
            q_id_r[i]   <= q_id_r[(i == 0) ? 0 : i - 1];
            q_prio_r[i] <= q_prio_r[(i == 0) ? 0 : i - 1];
          end
        end else if (q_deq && i < QUEUE_DEPTH - 1) begin
          q_id_r[i]   <= q_id_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
          q_prio_r[i] <= q_prio_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  assign s_top = s_cnt_r - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.exec && s_we) s_mem[s_cnt_r[SIDX_W-1:0]] <= id_r;
    s_rd_r <= s_mem[s_top[SIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
      s_cnt_r <= '0;
    end else if (cmd.exec) begin
      q_cnt_r <= q_cnt_nxt;
      s_cnt_r <= s_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status       <= st_nxt;
      out_task_id      <= rid_nxt;
      out_priority     <= rprio_nxt;
      out_stack_pushed <= pushed_nxt;
    end
  end

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_s_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s_cnt_r <= SCNT_W'(STACK_DEPTH)) else $error("stack count overflow");
  a_head_max: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt_r > QCNT_W'(1)) |-> (q_prio_r[0] >= q_prio_r[1]))
    else $error("queue head out of order");
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && mode_r == MODE_ENQ && !q_ok) |=> $stable(q_cnt_r))
    else $error("full queue changed");

endmodule

/* sim/tb_stable_priority_queue_with_low_stack.sv */
// self-checking testbench for stable_priority_queue_with_low_stack
// depends on spq_pkg and the block's rtl; predicts every result beat in-line
module tb_stable_priority_queue_with_low_stack import spq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 650;
  localparam int STALL_PCT    = 19;
  localparam int QUIET_LIMIT  = 2000;   // cycles with no beat on either side
  localparam int TAIL_CYCLES  = 8;      // margin for stray beats after the last result

  // one result beat as the block should present it
  typedef struct packed {
    status_t             status;
    logic [ID_W-1:0]     id;
    logic [PRIO_W-1:0]   prio;
    logic                pushed;
  } beat_result_t;

  // one row of the directed plan; want is used only when typed is set
  typedef struct packed {
    mode_t               mode;
    logic [ID_W-1:0]     id;
    logic [PRIO_W-1:0]   prio;
    logic                typed;
    beat_result_t        want;
  } plan_row_t;

  typedef struct packed {
    logic [PRIO_W-1:0]   prio;
    logic [ID_W-1:0]     id;
  } task_entry_t;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN_QUEUE,
    MIX_DRAIN_STACK,
    MIX_BALANCED
  } traffic_mix_t;

  localparam beat_result_t NONE  = '{ST_OK,    16'h0000, 2'd0, 1'b0};
  localparam beat_result_t EMPTY = '{ST_EMPTY, 16'h0000, 2'd0, 1'b0};
  localparam beat_result_t PUSH  = '{ST_OK,    16'h0000, 2'd0, 1'b1};

  // directed plan: empty removals, unused mode, id and priority extremes,
  // priority saturation, stable ordering of equal priorities, stack order
  localparam int PLAN_N = 20;
  localparam plan_row_t PLAN [PLAN_N] = '{
    '{MODE_DEQ, 16'h0000, 2'd0, 1'b1, EMPTY},
    '{MODE_POP, 16'hffff, 2'd3, 1'b1, EMPTY},
    '{MODE_NOP, 16'hffff, 2'd3, 1'b1, NONE},
    '{MODE_ENQ, 16'h0000, 2'd0, 1'b1, PUSH},
    '{MODE_ENQ, 16'hffff, 2'd3, 1'b1, NONE},
    '{MODE_ENQ, 16'h1234, 2'd1, 1'b0, NONE},
    '{MODE_ENQ, 16'h5678, 2'd2, 1'b0, NONE},
    '{MODE_ENQ, 16'haaaa, 2'd0, 1'b0, NONE},
    '{MODE_ENQ, 16'h5555, 2'd2, 1'b0, NONE},
    '{MODE_DEQ, 16'h0000, 2'd0, 1'b0, NONE},
    '{MODE_DEQ, 16'hffff, 2'd3, 1'b0, NONE},
    '{MODE_POP, 16'h0000, 2'd0, 1'b0, NONE},
    '{MODE_DEQ, 16'h0000, 2'd0, 1'b0, NONE},
    '{MODE_DEQ, 16'h0000, 2'd0, 1'b0, NONE},
    '{MODE_DEQ, 16'h0000, 2'd0, 1'b0, NONE},
    '{MODE_DEQ, 16'h0000, 2'd0, 1'b0, NONE},
    '{MODE_DEQ, 16'h0000, 2'd0, 1'b1, EMPTY},
    '{MODE_POP, 16'h0000, 2'd0, 1'b0, NONE},
    '{MODE_POP, 16'h0000, 2'd0, 1'b1, EMPTY},
    '{MODE_NOP, 16'h0000, 2'd0, 1'b1, NONE}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_mode = MODE_NOP;
  logic [ID_W-1:0]   in_task_id = '0;
  logic [PRIO_W-1:0] in_priority_req = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_status;
  logic [ID_W-1:0]   out_task_id;
  logic [PRIO_W-1:0] out_priority;
  logic              out_stack_pushed;

  // predictor state: sorted ready queue (head at index 0) and low stack (top at back)
  task_entry_t       ready_q[$];
  logic [ID_W-1:0]   low_stack[$];

  beat_result_t      awaited_results[$];
  int                errors = 0;
  int                quiet_cycles = 0;
  bit                no_idle = 1'b0;   // set during the stretch with no gaps or stalls

  stable_priority_queue_with_low_stack dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_task_id       (in_task_id),
    .in_priority_req  (in_priority_req),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_task_id      (out_task_id),
    .out_priority     (out_priority),
    .out_stack_pushed (out_stack_pushed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // apply one request to the predictor state and return the beat it causes;
  // queue insert and stack push are refused independently when full
  function automatic beat_result_t serve_request(mode_t mode, logic [ID_W-1:0] id,
                                                 logic [PRIO_W-1:0] prio_req);
    beat_result_t      res;
    task_entry_t       ent;
    logic [PRIO_W-1:0] prio;
    int                pos;
    res = NONE;
    // priority 3 is served as the top priority and never goes on the stack
    prio = (prio_req > PRIO_MAX) ? PRIO_MAX : prio_req;
    case (mode)
      MODE_ENQ: begin
        if (ready_q.size() >= QUEUE_DEPTH_DEF) begin
          res.status = ST_FULL;
        end else begin
          // stable insert: behind every entry of equal or larger priority
          pos = 0;
          while (pos < ready_q.size() && ready_q[pos].prio >= prio) pos++;
          ent.prio = prio;
          ent.id = id;
          ready_q.insert(pos, ent);
        end
        if (prio == PRIO_LOW) begin
          if (low_stack.size() >= STACK_DEPTH_DEF) begin
            res.status = ST_FULL;
          end else begin
            low_stack.push_back(id);
            res.pushed = 1'b1;
          end
        end
      end
      MODE_DEQ: begin
        if (ready_q.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          ent = ready_q.pop_front();
          res.id = ent.id;
          res.prio = ent.prio;
        end
      end
      MODE_POP: begin
        if (low_stack.size() == 0) res.status = ST_EMPTY;
        else res.id = low_stack.pop_back();
      end
      default: ;   // unused mode leaves everything alone
    endcase
    return res;
  endfunction

  // present one request beat, with random gaps ahead of it, and hold it
  // until accepted; the expected result is queued at the accepting edge
  task automatic issue_request(input mode_t mode, input logic [ID_W-1:0] id,
                               input logic [PRIO_W-1:0] prio, input logic typed,
                               input beat_result_t want);
    beat_result_t res;
    while (!no_idle && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_task_id <= id;
    in_priority_req <= prio;
    do @(posedge clk); while (in_stall);
    res = serve_request(mode, id, prio);
    // typed rows carry their result as written; the state still advances
    awaited_results.push_back(typed ? want : res);
  endtask

  // sender holds off until every result in flight has come back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input string field, input int want, input int got);
    errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  // result side: check each accepted beat, then pick the stall for the next edge
  initial begin
    beat_result_t exp;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, actual status %0h id %0h",
                   $time, out_status, out_task_id);
        end else begin
          exp = awaited_results.pop_front();
          if (out_status !== exp.status) note_mismatch("status", exp.status, out_status);
          if (out_task_id !== exp.id) note_mismatch("task_id", exp.id, out_task_id);
          if (out_priority !== exp.prio) note_mismatch("priority", exp.prio, out_priority);
          if (out_stack_pushed !== exp.pushed)
            note_mismatch("stack_pushed", exp.pushed, out_stack_pushed);
        end
      end
      out_stall <= !no_idle && ($urandom_range(0, 99) < STALL_PCT);
    end
  end

  // watchdog: too long with no beat on either channel ends the run
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall)) quiet_cycles++;
      else quiet_cycles = 0;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("tb_stable_priority_queue_with_low_stack NOT OK");
        $finish;
      end
    end
  end

  // request side: reset, directed plan, then bursts of biased random traffic
  initial begin
    int                row;
    int                counted;
    int                burst_left;
    int                pick;
    traffic_mix_t      mix;
    mode_t             mode;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;

    counted = 0;
    burst_left = 0;
    mix = MIX_BALANCED;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (row = 0; row < PLAN_N; row++) begin
      issue_request(PLAN[row].mode, PLAN[row].id, PLAN[row].prio,
                    PLAN[row].typed, PLAN[row].want);
    end

    // sender pause: everything must drain before random traffic starts
    hold_until_drained();

    // nop beats leave the block's state alone and are not counted
    while (counted < RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        // bursts lean toward filling the queue and stack, draining one of
        // them, or a balanced mix, to head for the full and empty corners
        mix = traffic_mix_t'($urandom_range(0, 3));
        burst_left = $urandom_range(10, 40);
      end
      burst_left--;
      no_idle = (counted >= 250 && counted < 380);
      if (counted == 450) hold_until_drained();

      pick = $urandom_range(0, 99);
      case (mix)
        MIX_FILL:        mode = (pick < 80) ? MODE_ENQ : (pick < 90) ? MODE_DEQ : MODE_POP;
        MIX_DRAIN_QUEUE: mode = (pick < 70) ? MODE_DEQ : (pick < 85) ? MODE_ENQ : MODE_POP;
        MIX_DRAIN_STACK: mode = (pick < 70) ? MODE_POP : (pick < 85) ? MODE_ENQ : MODE_DEQ;
        default:         mode = (pick < 40) ? MODE_ENQ : (pick < 70) ? MODE_DEQ : MODE_POP;
      endcase
      if ($urandom_range(0, 99) < 3) mode = MODE_NOP;

      pick = $urandom_range(0, 9);
      id = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hffff : ID_W'($urandom);
      prio = PRIO_W'($urandom_range(0, 3));

      issue_request(mode, id, prio, 1'b0, NONE);
      if (mode != MODE_NOP) counted++;
    end
    no_idle = 1'b0;

    // end of run: wait for the last results, then give stray beats a chance
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && awaited_results.size() == 0) begin
      $display("tb_stable_priority_queue_with_low_stack OK");
    end else begin
      $display("tb_stable_priority_queue_with_low_stack NOT OK");
    end
    $finish;
  end

endmodule

/* stable_priority_queue_with_low_stack.f */
hdl/spq_pkg.sv
hdl/spq_ctrl.sv
hdl/spq_dp.sv
hdl/stable_priority_queue_with_low_stack.sv
sim/tb_stable_priority_queue_with_low_stack.sv
